/* design/efr_pkg.sv */
// Package for the escaped frame receiver: widths, register indexes,
// result kinds and the result record passed between the receiver's stages.
// No dependencies.
package efr_pkg;

  localparam int ByteW    = 8;
  localparam int KindW    = 2;
  localparam int CfgIdxW  = 1;

  localparam logic [ByteW-1:0] SyncReset   = 8'hE0;
  localparam logic [ByteW-1:0] EscapeReset = 8'hD0;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SYNC   = 1'b0,
    REG_ESCAPE = 1'b1
  } cfg_reg_e;

  typedef enum logic [KindW-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_GOOD     = 2'd1,
    KIND_CSUM_ERR = 2'd2,
    KIND_ZERO_LEN = 2'd3
  } result_kind_e;

  typedef struct packed {
    result_kind_e     result_kind;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] byte_index;
    logic [ByteW-1:0] frame_destination;
    logic             frame_last;
  } result_t;

endpackage

/* design/efr_ifs.sv */
// Valid/ready channel interfaces of the escaped frame receiver.
// Depends on efr_pkg for the field widths.
interface efr_rx_if;
  logic                        valid;
  logic                        ready;
  logic [efr_pkg::ByteW-1:0]   rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface efr_res_if;
  logic                        valid;
  logic                        ready;
  logic [efr_pkg::KindW-1:0]   result_kind;
  logic [efr_pkg::ByteW-1:0]   payload_byte;
  logic [efr_pkg::ByteW-1:0]   byte_index;
  logic [efr_pkg::ByteW-1:0]   frame_destination;
  logic                        frame_last;

  modport source(output valid, output result_kind, output payload_byte, output byte_index,
                 output frame_destination, output frame_last, input ready);
  modport sink(input valid, input result_kind, input payload_byte, input byte_index,
               input frame_destination, input frame_last, output ready);
endinterface

/* design/efr_in_stage.sv */
// Input register of the escaped frame receiver: holds one received byte
// until the decode stage consumes it. Depends on efr_pkg.
module efr_in_stage (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  input  logic [efr_pkg::ByteW-1:0] byte_i,
  output logic                      ready_o,
  input  logic                      advance_i,
  output logic                      valid_o,
  output logic [efr_pkg::ByteW-1:0] byte_o
);

  logic                      valid_q;
  logic [efr_pkg::ByteW-1:0] byte_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_o = valid_q;
  assign byte_o  = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= byte_i;
    end
  end

endmodule

/* design/efr_decode.sv */
// Framing state and per-byte decode of the escaped frame receiver: escape
// handling, destination/length capture, payload indexing and checksum.
// Depends on efr_pkg.
module efr_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [efr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [efr_pkg::ByteW-1:0]   cfg_data_i,
  input  logic                        fire_i,
  input  logic [efr_pkg::ByteW-1:0]   byte_i,
  output logic                        res_valid_o,
  output efr_pkg::result_t            res_o
);

  typedef enum logic [1:0] {
    PH_DEST = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_e;

  logic [efr_pkg::ByteW-1:0] sync_q, escape_q;
  logic                      esc_q, esc_d;
  phase_e                    phase_q, phase_d;
  logic [efr_pkg::ByteW-1:0] dest_q, dest_d;
  logic [efr_pkg::ByteW-1:0] len_q, len_d;
  logic [efr_pkg::ByteW-1:0] cnt_q, cnt_d;
  logic [efr_pkg::ByteW-1:0] sum_q, sum_d;

  logic                      is_sync, is_esc;
  logic [efr_pkg::ByteW-1:0] data;

  assign is_sync = !esc_q && (byte_i == sync_q);
  assign is_esc  = !esc_q && (byte_i == escape_q);
  // An escaped byte stands for its value plus one.
  assign data    = esc_q ? byte_i + 8'd1 : byte_i;

  always_comb begin
    esc_d       = esc_q;
    phase_d     = phase_q;
    dest_d      = dest_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    sum_d       = sum_q;
    res_valid_o = 1'b0;
    res_o.result_kind       = efr_pkg::KIND_PAYLOAD;
    res_o.payload_byte      = '0;
    res_o.byte_index        = '0;
    res_o.frame_destination = dest_q;
    res_o.frame_last        = 1'b0;

    if (is_sync) begin
      phase_d = PH_DEST;
      cnt_d   = '0;
    end else if (is_esc) begin
      esc_d = 1'b1;
    end else begin
      esc_d = 1'b0;
      case (phase_q)
        PH_LEN: begin
          len_d = data;
          sum_d = sum_q + data;
          if (data == '0) begin
            phase_d           = PH_DEST;
            cnt_d             = '0;
            res_valid_o       = 1'b1;
            res_o.result_kind = efr_pkg::KIND_ZERO_LEN;
            res_o.frame_last  = 1'b1;
          end else begin
            phase_d = PH_BODY;
          end
        end
        PH_BODY: begin
          res_valid_o = 1'b1;
          if (cnt_q == len_q - 8'd1) begin
            phase_d           = PH_DEST;
            cnt_d             = '0;
            res_o.result_kind = (sum_q == data) ? efr_pkg::KIND_GOOD
                                                : efr_pkg::KIND_CSUM_ERR;
            res_o.frame_last  = 1'b1;
          end else begin
            res_o.payload_byte = data;
            res_o.byte_index   = cnt_q;
            cnt_d              = cnt_q + 8'd1;
            sum_d              = sum_q + data;
          end
        end
        default: begin
          dest_d  = data;
          sum_d   = data;
          cnt_d   = '0;
          phase_d = PH_LEN;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_q   <= efr_pkg::SyncReset;
      escape_q <= efr_pkg::EscapeReset;
      esc_q    <= 1'b0;
      phase_q  <= PH_DEST;
      dest_q   <= '0;
      len_q    <= '0;
      cnt_q    <= '0;
      sum_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          efr_pkg::REG_SYNC:   sync_q   <= cfg_data_i;
          efr_pkg::REG_ESCAPE: escape_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fire_i) begin
        esc_q   <= esc_d;
        phase_q <= phase_d;
        dest_q  <= dest_d;
        len_q   <= len_d;
        cnt_q   <= cnt_d;
        sum_q   <= sum_d;
      end
    end
  end

  a_sync_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_sync |=> phase_q == PH_DEST && cnt_q == '0)
    else $error("sync byte did not restart framing");

  a_escape_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    is_esc || is_sync |-> !res_valid_o)
    else $error("sync or escape byte produced a result");

  a_escape_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && esc_q |=> !esc_q)
    else $error("escape stayed pending past the escaped byte");

endmodule

/* design/efr_out_stage.sv */
// Result register of the escaped frame receiver: holds one result beat
// until the downstream side takes it. Depends on efr_pkg.
module efr_out_stage (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  efr_pkg::result_t res_i,
  output logic             free_o,
  output logic             valid_o,
  input  logic             ready_i,
  output efr_pkg::result_t res_o
);

  logic             valid_q;
  efr_pkg::result_t res_q;

  assign free_o  = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      res_q <= res_i;
    end
  end

endmodule

/* design/escaped_frame_receiver.sv */
// Top level of the escaped frame receiver: input register, decode stage
// and result register. Depends on efr_pkg, efr_ifs, efr_in_stage,
// efr_decode and efr_out_stage.
//
// Usage: raw serial bytes arrive one per beat on rx_if. An unescaped sync
// byte restarts framing without a result; an unescaped escape byte is
// dropped and makes the next byte count as its value plus one. The first
// framed byte is the destination, the second the length (payload count plus
// one). Each payload byte leaves on res_if as one beat with its index; the
// checksum byte yields a good or checksum-error beat with frame_last set, and
// a zero length yields a zero-length-error beat at once.
// The sync and escape values are written through cfg_we_i, cfg_idx_i and
// cfg_data_i while the block is idle.
// Throughput is one byte per cycle: the input register, one level of decode
// logic and the result register form a two-register path, and every byte,
// with or without a result, moves on only when the result register is free.
// A byte accepted into the input register passes through the decode logic into
// the result register once that register is free, and its result beat is then
// presented on res_if. When the receiver stalls, the result register holds
// its beat, the input register holds the next byte and rx_if.ready drops.
// Reset clears both registers' valid flags, the framing state and the
// escape flag, and restores the sync (0xE0) and escape (0xD0) values.
module escaped_frame_receiver (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [efr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [efr_pkg::ByteW-1:0]   cfg_data_i,
  efr_rx_if.sink                      rx_if,
  efr_res_if.source                   res_if
);

  logic                      in_valid;
  logic [efr_pkg::ByteW-1:0] in_byte;
  logic                      out_free;
  logic                      advance;
  logic                      res_valid;
  efr_pkg::result_t          res_d;
  efr_pkg::result_t          res_q;

  // The held byte moves on whenever the result register can take a beat;
  // a byte without a result simply leaves the register empty behind it.
  assign advance = in_valid && out_free;

  efr_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rx_if.valid),
    .byte_i    (rx_if.rx_byte),
    .ready_o   (rx_if.ready),
    .advance_i (advance),
    .valid_o   (in_valid),
    .byte_o    (in_byte)
  );

  efr_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (advance),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res_d)
  );

  efr_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (advance && res_valid),
    .res_i   (res_d),
    .free_o  (out_free),
    .valid_o (res_if.valid),
    .ready_i (res_if.ready),
    .res_o   (res_q)
  );

  assign res_if.result_kind       = res_q.result_kind;
  assign res_if.payload_byte      = res_q.payload_byte;
  assign res_if.byte_index        = res_q.byte_index;
  assign res_if.frame_destination = res_q.frame_destination;
  assign res_if.frame_last        = res_q.frame_last;

  a_last_matches_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_if.valid |->
      res_if.frame_last == (res_q.result_kind != efr_pkg::KIND_PAYLOAD))
    else $error("frame_last disagrees with the result kind");

  a_held_byte_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && !advance |=> in_valid && $stable(in_byte))
    else $error("held input byte was lost");

endmodule
